/* src/rfr_pkg.sv */
`timescale 1ns / 1ps

package rfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int STATUS_W = 2;

    localparam int BYTES_AFTER_HEADER_DEF = 22;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hA5;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_ALL_ONES = 16'hFFFF;

    // frame positions of the distance bytes (low first)
    localparam int DIST_LOW_POS  = 13;
    localparam int DIST_HIGH_POS = 14;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_ALL_ONES = 2'd2
    } frame_status_t;

    // one byte of reflected CRC-16, LSB first
    function automatic logic [CRC_W-1:0] crc_step(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* src/rfr_byte_if.sv */
`timescale 1ns / 1ps

interface rfr_byte_if;
    import rfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/rfr_result_if.sv */
`timescale 1ns / 1ps

interface rfr_result_if;
    import rfr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] frame_status;
    logic [CRC_W-1:0]    distance;
    logic [CRC_W-1:0]    received_crc;
    logic [CRC_W-1:0]    computed_crc;

    modport source (output valid, output frame_status, output distance,
                    output received_crc, output computed_crc, input ready);
    modport sink   (input valid, input frame_status, input distance,
                    input received_crc, input computed_crc, output ready);
endinterface

/* src/range_frame_receiver_crc16_core.sv */
`timescale 1ns / 1ps
// The result word is registered and appears in the cycle after the word holding the last frame byte.
// Throughput: one byte word per cycle; the CRC byte update is one combinational step.
// The input stalls only when the last frame byte arrives while a previous result
// word still sits unclaimed in the output register.
// Reset (rst_n low, async): hunting for the header, CRC at 0xFFFF, no result pending.

module range_frame_receiver_crc16_core #(
    parameter int BYTES_AFTER_HEADER = rfr_pkg::BYTES_AFTER_HEADER_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    rfr_byte_if.sink            in_bytes,
    rfr_result_if.source        frames
);
    import rfr_pkg::*;

    // Position counter must hold 0 .. BYTES_AFTER_HEADER.
    localparam int POS_W = $clog2(BYTES_AFTER_HEADER + 1);

    localparam logic [POS_W-1:0] HUNT_POS    = '0;
    localparam logic [POS_W-1:0] FIRST_POS   = POS_W'(1);
    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(BYTES_AFTER_HEADER);
    localparam logic [POS_W-1:0] CSUM_HI_POS = POS_W'(BYTES_AFTER_HEADER - 1);
    localparam logic [POS_W-1:0] CRC_END_POS = POS_W'(BYTES_AFTER_HEADER - 2);
    localparam logic [POS_W-1:0] DIST_LO_POS = POS_W'(DIST_LOW_POS);
    localparam logic [POS_W-1:0] DIST_HI_POS = POS_W'(DIST_HIGH_POS);

    // Frame tracking state. Position 0 means hunting for the header.
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [CRC_W-1:0]  crc_reg,  crc_next;
    logic [BYTE_W-1:0] dist_lo_reg, dist_lo_next;
    logic [BYTE_W-1:0] dist_hi_reg, dist_hi_next;
    logic [BYTE_W-1:0] csum_hi_reg, csum_hi_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    frame_status_t     status_reg,    status_next;
    logic [CRC_W-1:0]  dist_out_reg,  dist_out_next;
    logic [CRC_W-1:0]  rx_crc_reg,    rx_crc_next;
    logic [CRC_W-1:0]  calc_crc_reg,  calc_crc_next;

    logic              at_last;
    logic              in_accept;
    logic              out_accept;
    logic [CRC_W-1:0]  rx_crc;

    // Only the closing byte of a frame produces a result, so every other
    // byte is taken regardless of the output side.
    assign at_last        = (pos_reg == LAST_POS);
    assign in_bytes.ready = !at_last || !out_valid_reg || frames.ready;
    assign in_accept      = in_bytes.valid && in_bytes.ready;
    assign out_accept     = frames.valid && frames.ready;

    // Received checksum: high byte stored earlier, low byte is the current word.
    assign rx_crc = {csum_hi_reg, in_bytes.rx_byte};

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        dist_lo_next   = dist_lo_reg;
        dist_hi_next   = dist_hi_reg;
        csum_hi_next   = csum_hi_reg;
        out_valid_next = out_valid_reg && !out_accept;
        status_next    = status_reg;
        dist_out_next  = dist_out_reg;
        rx_crc_next    = rx_crc_reg;
        calc_crc_next  = calc_crc_reg;

        if (in_accept)
        begin
            if (pos_reg == HUNT_POS)
            begin
                // Anything but the header is dropped while hunting.
                if (in_bytes.rx_byte == HEADER_BYTE)
                begin
                    crc_next = crc_step(CRC_INIT, in_bytes.rx_byte);
                    pos_next = FIRST_POS;
                end
            end
            else
            begin
                // CRC covers the header through the byte before the checksum.
                if (pos_reg <= CRC_END_POS)
                begin
                    crc_next = crc_step(crc_reg, in_bytes.rx_byte);
                end
                if (pos_reg == DIST_LO_POS)
                begin
                    dist_lo_next = in_bytes.rx_byte;
                end
                if (pos_reg == DIST_HI_POS)
                begin
                    dist_hi_next = in_bytes.rx_byte;
                end
                if (pos_reg == CSUM_HI_POS)
                begin
                    csum_hi_next = in_bytes.rx_byte;
                end

                if (at_last)
                begin
                    // An all-ones checksum is rejected ahead of the compare.
                    if (rx_crc == CRC_ALL_ONES)
                    begin
                        status_next = STATUS_ALL_ONES;
                    end
                    else if (rx_crc != crc_reg)
                    begin
                        status_next = STATUS_MISMATCH;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                    end
                    out_valid_next = 1'b1;
                    dist_out_next  = {dist_hi_reg, dist_lo_reg};
                    rx_crc_next    = rx_crc;
                    calc_crc_next  = crc_reg;
                    pos_next       = HUNT_POS;
                    crc_next       = CRC_INIT;
                end
                else
                begin
                    pos_next = pos_reg + FIRST_POS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= HUNT_POS;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        dist_lo_reg  <= dist_lo_next;
        dist_hi_reg  <= dist_hi_next;
        csum_hi_reg  <= csum_hi_next;
        status_reg   <= status_next;
        dist_out_reg <= dist_out_next;
        rx_crc_reg   <= rx_crc_next;
        calc_crc_reg <= calc_crc_next;
    end

    assign frames.valid        = out_valid_reg;
    assign frames.frame_status = status_reg;
    assign frames.distance     = dist_out_reg;
    assign frames.received_crc = rx_crc_reg;
    assign frames.computed_crc = calc_crc_reg;

    // Position never runs past the closing byte.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position out of range");

    // While hunting, the running CRC sits at its initial value.
    a_hunt_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == HUNT_POS) |-> (crc_reg == CRC_INIT))
        else $error("CRC not reinitialized while hunting");

    // Closing byte sends the receiver back to hunting with a result pending.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && at_last) |=>
            (pos_reg == HUNT_POS) && (crc_reg == CRC_INIT) && out_valid_reg)
        else $error("frame end not handled");

    // A new result only appears after the closing byte of a frame.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept && at_last))
        else $error("result without a completed frame");

    // All-ones status matches exactly the all-ones checksum.
    a_status_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((status_reg == STATUS_ALL_ONES) == (rx_crc_reg == CRC_ALL_ONES)))
        else $error("all-ones status inconsistent");

endmodule

/* tb/range_frame_checker.sv */
`timescale 1ns / 1ps

module range_frame_checker #(
    parameter int TAIL = rfr_pkg::BYTES_AFTER_HEADER_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    rfr_byte_if   bytes_mon,
    rfr_result_if frames_mon,
    output int    mismatches,
    output int    frames_pending
);
    import rfr_pkg::*;

    typedef struct packed {
        frame_status_t     status;
        logic [CRC_W-1:0]  distance;
        logic [CRC_W-1:0]  rx_sum;
        logic [CRC_W-1:0]  calc_sum;
    } frame_result_t;

    frame_result_t     frames_due[$];

    int unsigned       frame_pos;     // 0 = hunting
    logic [CRC_W-1:0]  crc_acc;
    logic [BYTE_W-1:0] dist_lo;
    logic [BYTE_W-1:0] dist_hi;
    logic [BYTE_W-1:0] sum_hi;

    // reflected CRC-16, one data bit per shift
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  acc,
        input logic [BYTE_W-1:0] d
    );
        logic [CRC_W-1:0] r;
        r = acc;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (r[0] ^ d[i])
            begin
                r = (r >> 1) ^ CRC_POLY;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        frame_result_t r;
        if (frame_pos == 0)
        begin
            if (b == HEADER_BYTE)
            begin
                crc_acc   = crc16_byte(CRC_INIT, b);
                frame_pos = 1;
            end
        end
        else
        begin
            if (frame_pos + 2 <= TAIL)
            begin
                crc_acc = crc16_byte(crc_acc, b);
            end
            if (frame_pos == DIST_LOW_POS)
            begin
                dist_lo = b;
            end
            if (frame_pos == DIST_HIGH_POS)
            begin
                dist_hi = b;
            end
            if (frame_pos == TAIL - 1)
            begin
                sum_hi = b;
            end
            if (frame_pos >= TAIL)
            begin
                r.rx_sum   = {sum_hi, b};
                r.calc_sum = crc_acc;
                r.distance = {dist_hi, dist_lo};
                // all-ones checksum wins over the compare
                if (r.rx_sum == CRC_ALL_ONES)
                begin
                    r.status = STATUS_ALL_ONES;
                end
                else if (r.rx_sum != crc_acc)
                begin
                    r.status = STATUS_MISMATCH;
                end
                else
                begin
                    r.status = STATUS_OK;
                end
                frames_due.push_back(r);
                frame_pos = 0;
                crc_acc   = CRC_INIT;
            end
            else
            begin
                frame_pos = frame_pos + 1;
            end
        end
    endtask

    task automatic check_field(
        input string            name,
        input logic [CRC_W-1:0] want,
        input logic [CRC_W-1:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t e;
        if (!rst_n)
        begin
            frames_due.delete();
            frame_pos      = 0;
            crc_acc        = CRC_INIT;
            dist_lo        = '0;
            dist_hi        = '0;
            sum_hi         = '0;
            mismatches     = 0;
            frames_pending = 0;
        end
        else
        begin
            if (bytes_mon.valid && bytes_mon.ready)
            begin
                absorb_byte(bytes_mon.rx_byte);
            end
            if (frames_mon.valid && frames_mon.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result word with no frame pending");
                    mismatches = mismatches + 1;
                end
                else
                begin
                    e = frames_due.pop_front();
                    check_field("frame_status", CRC_W'(e.status),
                                CRC_W'(frames_mon.frame_status));
                    check_field("distance", e.distance, frames_mon.distance);
                    check_field("received_crc", e.rx_sum, frames_mon.received_crc);
                    check_field("computed_crc", e.calc_sum, frames_mon.computed_crc);
                end
            end
            frames_pending = frames_due.size();
        end
    end

endmodule

/* tb/tb_range_frame_receiver_crc16_core.sv */
`timescale 1ns / 1ps

module tb_range_frame_receiver_crc16_core;
    import rfr_pkg::*;

    localparam int LAST_POS       = BYTES_AFTER_HEADER_DEF;  // position of the last frame byte
    localparam int RESET_CYCLES   = 7;
    localparam int FRAME_COUNT    = 25;     // random frames, ~650 byte words
    localparam int DRAIN_AT_FRAME = 14;     // sender waits for all results here
    localparam int PHASE_LEN      = 160;    // byte words per idling phase
    localparam int HOLD_START     = 60;     // byte word count that triggers the long hold
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    typedef enum int {
        FRAME_GOOD,
        FRAME_CORRUPT,
        FRAME_ONES,
        FRAME_RANDOM_SUM
    } frame_kind_t;

    logic clk;
    logic rst_n;

    int bytes_sent;
    int quiet_cycles;
    int mismatches;
    int frames_pending;

    logic [BYTE_W-1:0] frame_q[$];

    rfr_byte_if   in_if();
    rfr_result_if out_if();

    range_frame_receiver_crc16_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_bytes (in_if),
        .frames   (out_if)
    );

    range_frame_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .bytes_mon      (in_if),
        .frames_mon     (out_if),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idling phases, keyed on how many byte words went in so far:
    //   0 no idling, 1 sender gaps, 2 receiver stalls, 3 both (lighter).
    function automatic int idle_pct(input bit rx_side);
        case ((bytes_sent / PHASE_LEN) % 4)
            1: return rx_side ? 0 : 61;
            2: return rx_side ? 61 : 0;
            3: return 26;
            default: return 0;
        endcase
    endfunction

    // Offer one byte word; inputs move on the falling edge only.
    // valid stays high across back-to-back words, so it is never
    // lowered and raised in the same step.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct(1'b0))
        begin
            @(negedge clk);
            in_if.valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_if.valid   = 1'b1;
        in_if.rx_byte = b;
        @(posedge clk);
        while (!in_if.ready)
        begin
            @(posedge clk);
        end
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_queue();
        while (frame_q.size() > 0)
        begin
            push_byte(frame_q.pop_front());
        end
    endtask

    // Drop valid and sit until the checker has nothing outstanding.
    task automatic drain_results();
        @(negedge clk);
        in_if.valid = 1'b0;
        wait (frames_pending == 0);
    endtask

    // Builds one frame into the queue. Payload bytes lean toward 0x00, 0xFF
    // and the header value so that distance extremes and header-as-data
    // show up often.
    task automatic build_frame(input frame_kind_t kind);
        logic [BYTE_W-1:0] fb [0:LAST_POS];
        logic [CRC_W-1:0]  c;
        int                sel;
        int                idx;
        fb[0] = HEADER_BYTE;
        for (int i = 1; i <= LAST_POS - 2; i++)
        begin
            sel = $urandom_range(15);
            if (sel == 0)
            begin
                fb[i] = 8'h00;
            end
            else if (sel == 1)
            begin
                fb[i] = 8'hFF;
            end
            else if (sel == 2)
            begin
                fb[i] = HEADER_BYTE;
            end
            else
            begin
                fb[i] = BYTE_W'($urandom_range(255));
            end
        end
        c = CRC_INIT;
        for (int i = 0; i <= LAST_POS - 2; i++)
        begin
            c = crc_step(c, fb[i]);
        end
        fb[LAST_POS-1] = c[15:8];
        fb[LAST_POS]   = c[7:0];
        case (kind)
            FRAME_CORRUPT:
            begin
                // one flipped bit anywhere after the header
                idx     = $urandom_range(LAST_POS, 1);
                fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7));
            end
            FRAME_ONES:
            begin
                fb[LAST_POS-1] = 8'hFF;
                fb[LAST_POS]   = 8'hFF;
            end
            FRAME_RANDOM_SUM:
            begin
                fb[LAST_POS-1] = BYTE_W'($urandom_range(255));
                fb[LAST_POS]   = BYTE_W'($urandom_range(255));
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i <= LAST_POS; i++)
        begin
            frame_q.push_back(fb[i]);
        end
    endtask

    // Result side: random stalls per phase, plus one long hold while the
    // sender keeps going at full rate, so the result register fills and
    // the block has to push back on its byte input.
    initial
    begin
        bit held;
        held         = 1'b0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !held && bytes_sent >= HOLD_START)
            begin
                held         = 1'b1;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_if.ready = ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // Watchdog: cycles with no word moving on either channel.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [BYTE_W-1:0] dfb [0:LAST_POS];
        logic [CRC_W-1:0]  pre;
        int                r;
        int                n;
        logic [BYTE_W-1:0] nb;
        rst_n         = 1'b0;
        in_if.valid   = 1'b0;
        in_if.rx_byte = '0;
        bytes_sent    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // Noise while hunting: both byte extremes and a near-miss header.
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        frame_q.push_back(HEADER_BYTE ^ 8'h01);
        send_queue();

        // One frame that hits several corner cases at once: a header value
        // right after the header (must be plain data), alternating all-zero
        // and all-one bytes, distance 0xFFFF, and an all-ones checksum that
        // also matches the computed CRC -- the all-ones rule has to win.
        dfb[0] = HEADER_BYTE;
        dfb[1] = HEADER_BYTE;
        for (int i = 2; i <= LAST_POS - 2; i++)
        begin
            dfb[i] = i[0] ? 8'hFF : 8'h00;
        end
        dfb[DIST_LOW_POS]  = 8'hFF;
        dfb[DIST_HIGH_POS] = 8'hFF;
        // The last two CRC-covered bytes map one-to-one onto the CRC value,
        // so exactly one pair lands the CRC on 0xFFFF.
        pre = CRC_INIT;
        for (int i = 0; i <= LAST_POS - 4; i++)
        begin
            pre = crc_step(pre, dfb[i]);
        end
        for (int a = 0; a < 256; a++)
        begin
            for (int b = 0; b < 256; b++)
            begin
                if (crc_step(crc_step(pre, 8'(a)), 8'(b)) == CRC_ALL_ONES)
                begin
                    dfb[LAST_POS-3] = 8'(a);
                    dfb[LAST_POS-2] = 8'(b);
                end
            end
        end
        dfb[LAST_POS-1] = 8'hFF;
        dfb[LAST_POS]   = 8'hFF;
        for (int i = 0; i <= LAST_POS; i++)
        begin
            frame_q.push_back(dfb[i]);
        end
        send_queue();

        // ---- random part ----
        for (int f = 0; f < FRAME_COUNT; f++)
        begin
            // a little line noise in front (never a header)
            n = $urandom_range(3);
            repeat (n)
            begin
                nb = BYTE_W'($urandom_range(255));
                if (nb == HEADER_BYTE)
                begin
                    nb = ~nb;
                end
                frame_q.push_back(nb);
            end
            // now and then a truncated frame; the next header then lands
            // inside it as data and throws the framing off for a while
            if ($urandom_range(11) == 0)
            begin
                frame_q.push_back(HEADER_BYTE);
                repeat ($urandom_range(LAST_POS - 2, 1))
                    frame_q.push_back(BYTE_W'($urandom_range(255)));
            end
            r = $urandom_range(9);
            if (r < 6)
            begin
                build_frame(FRAME_GOOD);
            end
            else if (r < 8)
            begin
                build_frame(FRAME_CORRUPT);
            end
            else if (r < 9)
            begin
                build_frame(FRAME_ONES);
            end
            else
            begin
                build_frame(FRAME_RANDOM_SUM);
            end
            send_queue();
            if (f == DRAIN_AT_FRAME)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/rfr_pkg.sv
src/rfr_byte_if.sv
src/rfr_result_if.sv
src/range_frame_receiver_crc16_core.sv
tb/range_frame_checker.sv
tb/tb_range_frame_receiver_crc16_core.sv
